// ===== rtl/core/sha256_hash_core_defines.svh =====
// assertion macros for the sha256 hash core
// expects signals named clk and arst_n in the module that uses them
`ifndef SHA256_HASH_CORE_DEFINES_SVH
`define SHA256_HASH_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies property in the next
`define SHA_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/core/sha_pkg.sv =====
// shared types, constants and round functions of the sha256 hash core
// no dependencies
`timescale 1ns / 1ps

package sha_pkg;

	localparam int WORDS_PER_BLOCK = 16;
	localparam int DEF_BLK_SLOTS   = 2;

	localparam logic [5:0] LAST_ROUND   = 6'd63;
	localparam logic [3:0] LAST_POS     = 4'd15;
	localparam logic [2:0] LAST_IDX_256 = 3'd7;
	localparam logic [2:0] LAST_IDX_224 = 3'd6;
	localparam logic       VARIANT_224  = 1'b1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_ADD,
		B_EMIT
	} sha_bstate_t;

	typedef struct packed {
		logic first;
		logic last;
	} sha_tok_t;

	typedef struct packed {
		logic     full;
		logic     empty;
		sha_tok_t head;
	} sha_qstat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] iv_word(input logic variant, input logic [2:0] idx);
		logic [31:0] r;
		if (variant == VARIANT_224) begin
			case (idx)
				3'd0: r = 32'hc1059ed8;
				3'd1: r = 32'h367cd507;
				3'd2: r = 32'h3070dd17;
				3'd3: r = 32'hf70e5939;
				3'd4: r = 32'hffc00b31;
				3'd5: r = 32'h68581511;
				3'd6: r = 32'h64f98fa7;
				default: r = 32'hbefa4fa4;
			endcase
		end else begin
			case (idx)
				3'd0: r = 32'h6a09e667;
				3'd1: r = 32'hbb67ae85;
				3'd2: r = 32'h3c6ef372;
				3'd3: r = 32'ha54ff53a;
				3'd4: r = 32'h510e527f;
				3'd5: r = 32'h9b05688c;
				3'd6: r = 32'h1f83d9ab;
				default: r = 32'h5be0cd19;
			endcase
		end
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98;
			6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;
			6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;
			6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;
			6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;
			6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;
			6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;
			6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;
			6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;
			6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;
			6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;
			6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;
			6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;
			6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;
			6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;
			6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;
			6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;
			6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;
			6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;
			6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;
			6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;
			6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;
			6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;
			6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/sha_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sha_blkq.sv =====
// queue of completed block transactions between front and back
// depends on sha_pkg
`timescale 1ns / 1ps

module sha_blkq #(
	parameter int BLK_SLOTS = sha_pkg::DEF_BLK_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  sha_pkg::sha_tok_t            push_tok,
	input  logic                         pop,
	output logic [$clog2(BLK_SLOTS)-1:0] wr_ptr,
	output logic [$clog2(BLK_SLOTS)-1:0] rd_ptr,
	output sha_pkg::sha_qstat_t          qstat
);

	localparam int PW = $clog2(BLK_SLOTS);
	localparam int CW = $clog2(BLK_SLOTS + 1);

	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	sha_pkg::sha_tok_t tok_q [BLK_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(BLK_SLOTS - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(BLK_SLOTS - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tok_q[wr_ptr_q] <= push_tok;
		end
	end

	assign wr_ptr      = wr_ptr_q;
	assign rd_ptr      = rd_ptr_q;
	assign qstat.full  = (count_q == CW'(BLK_SLOTS));
	assign qstat.empty = (count_q == '0);
	assign qstat.head  = tok_q[rd_ptr_q];

endmodule

// ===== rtl/core/sha_front.sv =====
// input side: variant register, word counter, block buffer writes, block push
// depends on sha_pkg
`timescale 1ns / 1ps

module sha_front #(
	parameter int BLK_SLOTS = sha_pkg::DEF_BLK_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    message_word,
	input  logic                           first_block,
	input  logic                           last_block,
	input  sha_pkg::sha_qstat_t            qstat,
	input  logic [$clog2(BLK_SLOTS)-1:0]   wr_ptr,
	output logic                           push,
	output sha_pkg::sha_tok_t              push_tok,
	output logic                           ram_we,
	output logic [$clog2(BLK_SLOTS)+3:0]   ram_waddr,
	output logic [31:0]                    ram_wdata,
	output logic                           variant
);

	logic [3:0] pos_q;
	logic       variant_q;
	logic       accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !qstat.full;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			variant_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				variant_q <= cfg_data;
			end
			if (accept) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	assign ram_we         = accept;
	assign ram_waddr      = {wr_ptr, pos_q};
	assign ram_wdata      = message_word;
	assign push           = accept && (pos_q == sha_pkg::LAST_POS);
	assign push_tok.first = first_block;
	assign push_tok.last  = last_block;
	assign variant        = variant_q;

endmodule

// ===== rtl/core/sha_back.sv =====
// compression side: schedule window, round unit, chaining words, digest output
// depends on sha_pkg and sha256_hash_core_defines.svh
`timescale 1ns / 1ps
`include "sha256_hash_core_defines.svh"

module sha_back #(
	parameter int BLK_SLOTS = sha_pkg::DEF_BLK_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         variant,
	input  sha_pkg::sha_qstat_t          qstat,
	input  logic [$clog2(BLK_SLOTS)-1:0] rd_ptr,
	output logic                         pop,
	output logic [$clog2(BLK_SLOTS)+3:0] ram_raddr,
	input  logic [31:0]                  ram_rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [31:0]                  digest_word,
	output logic [2:0]                   word_index,
	output logic                         digest_last
);

	sha_pkg::sha_bstate_t state_q, state_d;

	logic [5:0]  t_q;
	logic [2:0]  idx_q;
	logic        last_q;
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [16];
	logic [31:0] wx_q;
	logic [31:0] start_v [8];

	logic [31:0] cur_w;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] choose;
	logic [31:0] major;
	logic [2:0]  last_idx;

	assign last_idx = (variant == sha_pkg::VARIANT_224) ? sha_pkg::LAST_IDX_224
	                                                    : sha_pkg::LAST_IDX_256;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			start_v[i] = qstat.head.first ? sha_pkg::iv_word(variant, 3'(i)) : chain_q[i];
		end
	end

	// round datapath
	assign cur_w  = (t_q[5:4] == 2'b00) ? ram_rdata : wx_q;
	assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1     = v_q[7] + sha_pkg::big_s1(v_q[4]) + choose + sha_pkg::round_k(t_q) + cur_w;
	assign t2     = sha_pkg::big_s0(v_q[0]) + major;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::B_IDLE;
			t_q     <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha_pkg::iv_word(1'b0, 3'(i));
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				sha_pkg::B_IDLE: begin
					if (!qstat.empty) begin
						for (int i = 0; i < 8; i++) begin
							chain_q[i] <= start_v[i];
						end
						last_q <= qstat.head.last;
						t_q    <= '0;
					end
				end
				sha_pkg::B_RUN: begin
					t_q <= t_q + 6'd1;
				end
				sha_pkg::B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					idx_q <= '0;
				end
				sha_pkg::B_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
					end
				end
				default: begin
					t_q <= t_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// next schedule word, registered from the window before the round that uses it
		wx_q <= win_q[1] + sha_pkg::small_s0(win_q[2]) + win_q[10]
		      + sha_pkg::small_s1(win_q[15]);
		if (state_q == sha_pkg::B_IDLE) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= start_v[i];
			end
		end else if (state_q == sha_pkg::B_RUN) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= cur_w;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::B_IDLE: if (!qstat.empty) state_d = sha_pkg::B_RUN;
			sha_pkg::B_RUN:  if (t_q == sha_pkg::LAST_ROUND) state_d = sha_pkg::B_ADD;
			sha_pkg::B_ADD:  state_d = last_q ? sha_pkg::B_EMIT : sha_pkg::B_IDLE;
			sha_pkg::B_EMIT: if (out_ready && (idx_q == last_idx)) state_d = sha_pkg::B_IDLE;
			default:         state_d = sha_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop         = (state_q == sha_pkg::B_ADD);
		out_valid   = (state_q == sha_pkg::B_EMIT);
		ram_raddr   = {rd_ptr, (state_q == sha_pkg::B_RUN) ? t_q[3:0] + 4'd1 : 4'd0};
		digest_word = chain_q[idx_q];
		word_index  = idx_q;
		digest_last = (idx_q == last_idx);
	end

	`SHA_ASSERT(a_pop_nonempty, pop |-> !qstat.empty, "block released from an empty queue")
	`SHA_ASSERT_NEXT(a_run_to_add, (state_q == sha_pkg::B_RUN) && (t_q == sha_pkg::LAST_ROUND), state_q == sha_pkg::B_ADD, "final round not followed by chaining add")
	`SHA_ASSERT_NEXT(a_last_ends, out_valid && out_ready && digest_last, (state_q == sha_pkg::B_IDLE) && !out_valid, "digest output continues past last word")

endmodule

// ===== rtl/core/sha256_hash_core.sv =====
// top level of the sha256 / sha224 hash core
// depends on sha_pkg, sha_front, sha_blkq, sha_ram, sha_back
`timescale 1ns / 1ps

// usage:
// - input channel (in_valid/in_ready) takes one padded 32-bit message word per
//   transaction; first_block and last_block count only on the 16th word of a block
// - cfg channel (cfg_valid/cfg_ready) writes the variant bit: 0 sha-256, 1 sha-224;
//   write only while the core is idle
// - output channel (out_valid/out_ready) gives the digest after a last block:
//   8 words for sha-256, 7 for sha-224, word_index 0 first, digest_last on the end
// - words go into a block buffer ram of BLK_SLOTS blocks, so input keeps flowing
//   while an earlier block is compressed or its digest waits
// - one block passes through the round unit as 1 load, 64 rounds and 1 add,
//   one round per cycle
// - digest follows the last block's rounds and add when the round unit is free,
//   then one word per cycle while out_ready is high
// - a stalled output holds the round unit; input stops once all slots are full
// - reset loads the sha-256 initial values, clears the word count and the queue
module sha256_hash_core #(
	parameter int BLK_SLOTS = sha_pkg::DEF_BLK_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] message_word,
	input  logic        first_block,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);

	localparam int PW = $clog2(BLK_SLOTS);
	localparam int AW = PW + 4;

	sha_pkg::sha_qstat_t qstat;
	sha_pkg::sha_tok_t   push_tok;
	logic                push;
	logic                pop;
	logic [PW-1:0]       wr_ptr;
	logic [PW-1:0]       rd_ptr;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [31:0]         ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [31:0]         ram_rdata;
	logic                variant;

	sha_front #(.BLK_SLOTS(BLK_SLOTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.message_word (message_word),
		.first_block  (first_block),
		.last_block   (last_block),
		.qstat        (qstat),
		.wr_ptr       (wr_ptr),
		.push         (push),
		.push_tok     (push_tok),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.variant      (variant)
	);

	sha_blkq #(.BLK_SLOTS(BLK_SLOTS)) u_blkq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.wr_ptr   (wr_ptr),
		.rd_ptr   (rd_ptr),
		.qstat    (qstat)
	);

	sha_ram #(
		.WIDTH (32),
		.DEPTH (BLK_SLOTS * sha_pkg::WORDS_PER_BLOCK)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sha_back #(.BLK_SLOTS(BLK_SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.variant     (variant),
		.qstat       (qstat),
		.rd_ptr      (rd_ptr),
		.pop         (pop),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.digest_last (digest_last)
	);

endmodule

// ===== tb/sha256_hash_core_test.sv =====
// self-checking testbench for the sha256 / sha224 hash core
// needs sha_pkg and sha256_hash_core; predicts digests with its own round model
`timescale 1ns / 1ps

module sha256_hash_core_test;

	localparam logic VARIANT_256 = 1'b0;
	localparam int TOTAL_ITEMS   = 460;
	localparam int DIRECTED_ROWS = 32;
	localparam int IDLE_WAIT     = 300;
	localparam int DRAIN_CYCLES  = 200;
	localparam int LONG_HOLD     = 1500;
	localparam int STALL_PHASE   = 2;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_256 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] IV_224 [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [31:0] ABC_DIGEST [8] = '{
		32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
		32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
	};

	typedef struct packed {
		logic [31:0] word;
		logic        first;
		logic        last;
		logic        known_abc;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_entry_t;

	// "abc" right after reset with no first flag, then a block of all-ones words with a zero last word
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h61626380, 1'b1, 1'b1, 1'b0},
		'{32'h00000000, 1'b0, 1'b1, 1'b0},
		'{32'h00000000, 1'b1, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0, 1'b0},
		'{32'h00000018, 1'b0, 1'b1, 1'b1},
		'{32'hffffffff, 1'b1, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b1, 1'b0},
		'{32'hffffffff, 1'b1, 1'b1, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0, 1'b0},
		'{32'h00000000, 1'b1, 1'b1, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] message_word;
	logic        first_block;
	logic        last_block;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	logic [31:0]   chain [8];
	logic [31:0]   block_words [16];
	logic [3:0]    fill_pos;
	logic          active_variant;
	digest_entry_t digest_q [$];
	int            error_count;
	int            sent_count;
	bit            msg_open;
	bit            stall_request;

	sha256_hash_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.message_word (message_word),
		.first_block  (first_block),
		.last_block   (last_block),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.digest_last  (digest_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [31:0] rotate_right(input logic [31:0] x, input int n);
		logic [63:0] doubled;
		doubled = {x, x} >> n;
		return doubled[31:0];
	endfunction

	function automatic void compress_into_chain();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int i;
		for (i = 0; i < sha_pkg::WORDS_PER_BLOCK; i++)
			sched[i] = block_words[i];
		for (i = sha_pkg::WORDS_PER_BLOCK; i < 64; i++) begin
			s0 = rotate_right(sched[i-15], 7) ^ rotate_right(sched[i-15], 18)
				^ (sched[i-15] >> 3);
			s1 = rotate_right(sched[i-2], 17) ^ rotate_right(sched[i-2], 19)
				^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		for (i = 0; i < 8; i++)
			v[i] = chain[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7]
				+ (rotate_right(v[4], 6) ^ rotate_right(v[4], 11) ^ rotate_right(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
			t2 = (rotate_right(v[0], 2) ^ rotate_right(v[0], 13) ^ rotate_right(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic void absorb_word(input logic [31:0] word, input logic first,
			input logic last, input logic known_abc);
		digest_entry_t entry;
		logic [2:0] last_idx;
		int k;
		block_words[fill_pos] = word;
		if (fill_pos != sha_pkg::LAST_POS) begin
			fill_pos = fill_pos + 4'd1;
			return;
		end
		fill_pos = '0;
		if (first) begin
			for (k = 0; k < 8; k++)
				chain[k] = (active_variant == sha_pkg::VARIANT_224) ? IV_224[k] : IV_256[k];
		end
		compress_into_chain();
		if (!last)
			return;
		last_idx = (active_variant == sha_pkg::VARIANT_224) ? sha_pkg::LAST_IDX_224
		                                                   : sha_pkg::LAST_IDX_256;
		for (k = 0; k <= int'(last_idx); k++) begin
			entry.word = known_abc ? ABC_DIGEST[k] : chain[k];
			entry.idx  = k[2:0];
			entry.last = (k == int'(last_idx));
			digest_q.push_back(entry);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'h00000000;
		if (r < 16)
			return 32'hffffffff;
		return $urandom;
	endfunction

	task automatic send_word(input logic [31:0] word, input logic first, input logic last,
			input logic known_abc);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		message_word = word;
		first_block  = first;
		last_block   = last;
		do @(posedge clk); while (!in_ready);
		absorb_word(word, first, last, known_abc);
		sent_count++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_block(input bit end_msg);
		logic first, last;
		int k;
		if ($urandom_range(0, 99) < 85) begin
			first    = !msg_open;
			last     = 1'($urandom_range(0, 1));
			msg_open = !last;
		end else begin
			first = 1'($urandom_range(0, 1));
			last  = 1'($urandom_range(0, 1));
		end
		if (end_msg) begin
			last     = 1'b1;
			msg_open = 1'b0;
		end
		// flags on the first fifteen words are don't-care
		for (k = 0; k < sha_pkg::WORDS_PER_BLOCK - 1; k++)
			send_word(pick_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'b0);
		send_word(pick_word(), first, last, 1'b0);
	endtask

	task automatic write_variant(input logic value);
		while (digest_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		active_variant = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin : out_side
		int run;
		int gap;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			out_ready = 1'b1;
			run = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8) : $urandom_range(50, 200);
			repeat (run) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_digest
		digest_entry_t oldest;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected digest transaction: word %h index %0d last %b",
						digest_word, word_index, digest_last);
			end else begin
				oldest = digest_q.pop_front();
				if (oldest.word !== digest_word || oldest.idx !== word_index
						|| oldest.last !== digest_last) begin
					error_count++;
					if (error_count <= 10)
						$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
							oldest.word, oldest.idx, oldest.last,
							digest_word, word_index, digest_last);
				end
			end
		end
	end

	initial begin : in_side
		int i;
		int b;
		int phase;
		int nblocks;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 1'b0;
		in_valid       = 1'b0;
		message_word   = '0;
		first_block    = 1'b0;
		last_block     = 1'b0;
		error_count    = 0;
		sent_count     = 0;
		msg_open       = 1'b0;
		stall_request  = 1'b0;
		fill_pos       = '0;
		active_variant = VARIANT_256;
		for (i = 0; i < 8; i++)
			chain[i] = IV_256[i];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_word(directed_rows[i].word, directed_rows[i].first,
				directed_rows[i].last, directed_rows[i].known_abc);
		release_input();

		phase = 0;
		while (sent_count < TOTAL_ITEMS) begin
			if (phase == 0)
				write_variant(VARIANT_224);
			else if (phase == 1)
				write_variant(sha_pkg::VARIANT_224 ^ 1'b1);
			else
				write_variant(1'($urandom_range(0, 1)));
			// hold starts before the first block, whose digest then backs up the core
			if (phase == STALL_PHASE) begin
				stall_request = 1'b1;
				wait (!stall_request);
			end
			nblocks = (phase == STALL_PHASE) ? 6 : $urandom_range(3, 5);
			for (b = 0; b < nblocks; b++)
				send_block(phase == STALL_PHASE && b == 0);
			release_input();
			phase++;
		end

		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && digest_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	localparam logic VARIANT_224 = sha_pkg::VARIANT_224;

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_ram.sv
rtl/core/sha_blkq.sv
rtl/core/sha_front.sv
rtl/core/sha_back.sv
rtl/core/sha256_hash_core.sv
tb/sha256_hash_core_test.sv
